@@ rtl/core/i2car_pkg.sv @@
// Shared types and constants for the I2C converter reader with sample averaging.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package i2car_pkg;

  localparam int NUM_SAMPLES = 8;
  localparam int RESULT_W    = 16;

  // opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CONFIG = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_SETUP_BYTE     = 2'd1;
  localparam logic [1:0] CFG_PHASE_TICKS    = 2'd2;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd72;
  localparam logic [7:0] SETUP_BYTE_RST     = 8'h8C;
  localparam logic [7:0] PHASE_TICKS_RST    = 8'd15;

  localparam logic [2:0] BYTE_LAST_BIT = 3'd7;

  // which byte of the transaction is in flight
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C,
    PH_TX_D, PH_TX_H, PH_TX_L,
    PH_AK_R, PH_AK_H, PH_AK_L,
    PH_RX_H, PH_RX_L,
    PH_MA_D, PH_MA_H, PH_MA_L, PH_MA_R,
    PH_NK_D, PH_NK_H, PH_NK_L,
    PH_SP_D, PH_SP_H, PH_SP_R
  } phase_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] setup_byte;
    logic [7:0] phase_ticks;
  } cfg_t;

  // sequencer -> averager
  typedef struct packed {
    logic                clear;
    logic                add;
    logic                sample_end;
    logic [RESULT_W-1:0] word;
  } avg_cmd_t;

  // sequencer view after the current tick
  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic done;
    logic done_read;
  } seq_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/i2car_avg.sv @@
// Sample accumulator, sample counter and constant-reciprocal mean.
// Depends on i2car_pkg.
`default_nettype none

module i2car_avg #(
  parameter int NumSamples = i2car_pkg::NUM_SAMPLES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire i2car_pkg::avg_cmd_t           cmd,
  output logic                               last_sample,
  output logic [i2car_pkg::RESULT_W-1:0]     mean
);

  localparam int Log2N      = $clog2(NumSamples);
  localparam int SumW       = i2car_pkg::RESULT_W + Log2N;
  localparam int CntW       = (NumSamples > 1) ? Log2N : 1;
  localparam int RecipShift = SumW + Log2N;
  // ceil(2^RecipShift / N): exact floor division for any sum below 2^SumW
  localparam logic [63:0] RecipFull =
    ((64'd1 << RecipShift) + 64'(NumSamples) - 64'd1) / 64'(NumSamples);
  localparam logic [SumW:0] Recip = RecipFull[SumW:0];

  logic [SumW-1:0]     sum_r,   sum_nxt;
  logic [CntW-1:0]     cnt_r,   cnt_nxt;
  logic [2*SumW:0]     prod;

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else begin
      if (cmd.add) begin
        sum_nxt = sum_r + SumW'(cmd.word);
      end
      if (cmd.sample_end) begin
        cnt_nxt = cnt_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (step) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign last_sample = (cnt_r == CntW'(NumSamples - 1));
  assign prod        = (2*SumW+1)'(sum_r) * (2*SumW+1)'(Recip);
  assign mean        = prod[RecipShift +: i2car_pkg::RESULT_W];

endmodule

`default_nettype wire

@@ rtl/core/i2car_seq.sv @@
// Bus phase sequencer: start, byte send, acknowledge, byte receive, stop.
// One tick per step; depends on i2car_pkg.
`default_nettype none

module i2car_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [1:0]            opcode,
  input  wire logic                  sda_in,
  input  wire i2car_pkg::cfg_t       cfg,
  input  wire logic                  last_sample,
  output i2car_pkg::avg_cmd_t        cmd,
  output i2car_pkg::seq_stat_t       stat
);

  i2car_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] tick_r,  tick_nxt;
  logic [2:0] bit_r,   bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] high_r,  high_nxt;
  logic [1:0] slot_r,  slot_nxt;
  logic       read_r,  read_nxt;
  logic       scl_r,   scl_nxt;
  logic       sda_r,   sda_nxt;
  logic       enter;
  logic       done;
  logic [7:0] hold;
  logic [7:0] tick_inc;

  assign hold     = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
  assign tick_inc = tick_r + 8'd1;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    high_nxt  = high_r;
    slot_nxt  = slot_r;
    read_nxt  = read_r;
    enter     = 1'b0;
    done      = 1'b0;
    cmd       = '0;
    if (phase_r == i2car_pkg::PH_IDLE) begin
      if (opcode == i2car_pkg::OP_CONFIG || opcode == i2car_pkg::OP_READ) begin
        read_nxt  = (opcode == i2car_pkg::OP_READ);
        slot_nxt  = i2car_pkg::SLOT_FIRST;
        cmd.clear = (opcode == i2car_pkg::OP_READ);
        phase_nxt = i2car_pkg::PH_ST_A;
        enter     = 1'b1;
      end
    end else begin
      tick_nxt = tick_inc;
      if (tick_inc >= hold) begin
        enter = 1'b1;
        unique case (phase_r)
          i2car_pkg::PH_ST_A: phase_nxt = sda_in ? i2car_pkg::PH_ST_B : i2car_pkg::PH_ST_A;
          i2car_pkg::PH_ST_B: phase_nxt = sda_in ? i2car_pkg::PH_ST_A : i2car_pkg::PH_ST_C;
          i2car_pkg::PH_ST_C: begin
            slot_nxt  = i2car_pkg::SLOT_FIRST;
            shift_nxt = {cfg.device_address, read_r};
            bit_nxt   = '0;
            phase_nxt = i2car_pkg::PH_TX_D;
          end
          i2car_pkg::PH_TX_D: phase_nxt = i2car_pkg::PH_TX_H;
          i2car_pkg::PH_TX_H: phase_nxt = i2car_pkg::PH_TX_L;
          i2car_pkg::PH_TX_L: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            if (bit_r == i2car_pkg::BYTE_LAST_BIT) begin
              phase_nxt = i2car_pkg::PH_AK_R;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = i2car_pkg::PH_TX_D;
            end
          end
          i2car_pkg::PH_AK_R: phase_nxt = i2car_pkg::PH_AK_H;
          // no acknowledge: release and clock it again
          i2car_pkg::PH_AK_H: phase_nxt = sda_in ? i2car_pkg::PH_AK_R : i2car_pkg::PH_AK_L;
          i2car_pkg::PH_AK_L: begin
            if (read_r) begin
              slot_nxt  = i2car_pkg::SLOT_SECOND;
              shift_nxt = '0;
              bit_nxt   = '0;
              phase_nxt = i2car_pkg::PH_RX_H;
            end else if (slot_r == i2car_pkg::SLOT_FIRST) begin
              slot_nxt  = i2car_pkg::SLOT_SECOND;
              shift_nxt = cfg.setup_byte;
              bit_nxt   = '0;
              phase_nxt = i2car_pkg::PH_TX_D;
            end else begin
              phase_nxt = i2car_pkg::PH_SP_D;
            end
          end
          i2car_pkg::PH_RX_H: begin
            shift_nxt = {shift_r[6:0], sda_in};
            phase_nxt = i2car_pkg::PH_RX_L;
          end
          i2car_pkg::PH_RX_L: begin
            if (bit_r != i2car_pkg::BYTE_LAST_BIT) begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = i2car_pkg::PH_RX_H;
            end else if (slot_r == i2car_pkg::SLOT_SECOND) begin
              high_nxt  = shift_r;
              phase_nxt = i2car_pkg::PH_MA_D;
            end else if (slot_r == i2car_pkg::SLOT_THIRD) begin
              cmd.add   = 1'b1;
              cmd.word  = {high_r, shift_r};
              phase_nxt = i2car_pkg::PH_MA_D;
            end else begin
              phase_nxt = i2car_pkg::PH_NK_D;
            end
          end
          i2car_pkg::PH_MA_D: phase_nxt = i2car_pkg::PH_MA_H;
          i2car_pkg::PH_MA_H: phase_nxt = i2car_pkg::PH_MA_L;
          i2car_pkg::PH_MA_L: phase_nxt = i2car_pkg::PH_MA_R;
          i2car_pkg::PH_MA_R: begin
            slot_nxt  = slot_r + 2'd1;
            shift_nxt = '0;
            bit_nxt   = '0;
            phase_nxt = i2car_pkg::PH_RX_H;
          end
          i2car_pkg::PH_NK_D: phase_nxt = i2car_pkg::PH_NK_H;
          i2car_pkg::PH_NK_H: phase_nxt = i2car_pkg::PH_NK_L;
          i2car_pkg::PH_NK_L: phase_nxt = i2car_pkg::PH_SP_D;
          i2car_pkg::PH_SP_D: phase_nxt = i2car_pkg::PH_SP_H;
          i2car_pkg::PH_SP_H: phase_nxt = i2car_pkg::PH_SP_R;
          i2car_pkg::PH_SP_R: begin
            if (read_r) begin
              cmd.sample_end = 1'b1;
              if (last_sample) begin
                done      = 1'b1;
                phase_nxt = i2car_pkg::PH_IDLE;
              end else begin
                phase_nxt = i2car_pkg::PH_ST_A;
              end
            end else begin
              done      = 1'b1;
              phase_nxt = i2car_pkg::PH_IDLE;
            end
          end
          default: phase_nxt = i2car_pkg::PH_IDLE;
        endcase
      end
    end
    if (enter) begin
      tick_nxt = '0;
    end
  end

  // line drives, set on entry to a phase
  always_comb begin
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    if (enter) begin
      unique case (phase_nxt)
        i2car_pkg::PH_ST_A: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        i2car_pkg::PH_ST_B: sda_nxt = 1'b0;
        i2car_pkg::PH_ST_C: scl_nxt = 1'b0;
        i2car_pkg::PH_TX_D: begin
          scl_nxt = 1'b0;
          sda_nxt = shift_nxt[7];
        end
        i2car_pkg::PH_TX_H: scl_nxt = 1'b1;
        i2car_pkg::PH_TX_L: begin
          scl_nxt = 1'b0;
          sda_nxt = (bit_nxt == i2car_pkg::BYTE_LAST_BIT) ? 1'b1 : shift_nxt[7];
        end
        i2car_pkg::PH_AK_R: sda_nxt = 1'b1;
        i2car_pkg::PH_AK_H: scl_nxt = 1'b1;
        i2car_pkg::PH_AK_L: scl_nxt = 1'b0;
        i2car_pkg::PH_RX_H: scl_nxt = 1'b1;
        i2car_pkg::PH_RX_L: scl_nxt = 1'b0;
        i2car_pkg::PH_MA_D: sda_nxt = 1'b0;
        i2car_pkg::PH_MA_H: scl_nxt = 1'b1;
        i2car_pkg::PH_MA_L: scl_nxt = 1'b0;
        i2car_pkg::PH_MA_R: sda_nxt = 1'b1;
        i2car_pkg::PH_NK_D: sda_nxt = 1'b1;
        i2car_pkg::PH_NK_H: scl_nxt = 1'b1;
        i2car_pkg::PH_NK_L: scl_nxt = 1'b0;
        i2car_pkg::PH_SP_D: sda_nxt = 1'b0;
        i2car_pkg::PH_SP_H: scl_nxt = 1'b1;
        i2car_pkg::PH_SP_R: sda_nxt = 1'b1;
        default: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2car_pkg::PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      high_r  <= '0;
      slot_r  <= i2car_pkg::SLOT_FIRST;
      read_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      high_r  <= high_nxt;
      slot_r  <= slot_nxt;
      read_r  <= read_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  assign stat.scl       = scl_nxt;
  assign stat.sda       = sda_nxt;
  assign stat.busy      = (phase_nxt != i2car_pkg::PH_IDLE);
  assign stat.done      = done;
  assign stat.done_read = done & read_r;

endmodule

`default_nettype wire

@@ rtl/core/i2c_adc_reader_averager_unit.sv @@
// Top level: I2C master reading a converter and averaging samples.
// Instantiates i2car_seq and i2car_avg; depends on i2car_pkg.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | in_opcode, in_sda_in
//   out_    | output    | out_valid / out_ready  | out_scl_out, out_sda_out, out_busy_res,
//           |           |                        | out_done_res, out_average_value
//   cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready is high; a result passes through the input register
// and then the result register, with the phase sequencer's next-state logic combinational between
// them (the mean is one multiply by a constant reciprocal).
// Reset is synchronous, active low; no clearing pass.
// A stalled result holds in the output register; the input register keeps taking
// items as long as the result register drains.
`default_nettype none

module i2c_adc_reader_averager_unit #(
  parameter int NumSamples = i2car_pkg::NUM_SAMPLES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_opcode,
  input  wire logic                             in_sda_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_scl_out,
  output logic                                  out_sda_out,
  output logic                                  out_busy_res,
  output logic                                  out_done_res,
  output logic [i2car_pkg::RESULT_W-1:0]        out_average_value,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [7:0]                       cfg_wdata
);

  i2car_pkg::cfg_t      cfg_r;
  i2car_pkg::avg_cmd_t  avg_cmd;
  i2car_pkg::seq_stat_t stat;

  logic                          in_valid_r;
  logic [1:0]                    opcode_r;
  logic                          sda_r;
  logic                          step;
  logic                          last_sample;
  logic [i2car_pkg::RESULT_W-1:0] mean;

  logic                          out_valid_r;
  logic                          scl_out_r;
  logic                          sda_out_r;
  logic                          busy_r;
  logic                          done_r;
  logic [i2car_pkg::RESULT_W-1:0] average_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= i2car_pkg::DEVICE_ADDRESS_RST;
      cfg_r.setup_byte     <= i2car_pkg::SETUP_BYTE_RST;
      cfg_r.phase_ticks    <= i2car_pkg::PHASE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2car_pkg::CFG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_wdata[6:0];
        i2car_pkg::CFG_SETUP_BYTE:     cfg_r.setup_byte     <= cfg_wdata;
        i2car_pkg::CFG_PHASE_TICKS:    cfg_r.phase_ticks    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a tick is processed when the result register is free or draining
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      opcode_r <= in_opcode;
      sda_r    <= in_sda_in;
    end
  end

  i2car_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .opcode      (opcode_r),
    .sda_in      (sda_r),
    .cfg         (cfg_r),
    .last_sample (last_sample),
    .cmd         (avg_cmd),
    .stat        (stat)
  );

  i2car_avg #(
    .NumSamples (NumSamples)
  ) u_avg (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .cmd         (avg_cmd),
    .last_sample (last_sample),
    .mean        (mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      scl_out_r <= stat.scl;
      sda_out_r <= stat.sda;
      busy_r    <= stat.busy;
      done_r    <= stat.done;
      average_r <= stat.done_read ? mean : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scl_out       = scl_out_r;
  assign out_sda_out       = sda_out_r;
  assign out_busy_res      = busy_r;
  assign out_done_res      = done_r;
  assign out_average_value = average_r;

endmodule

`default_nettype wire

@@ rtl/core/i2car_chk.sv @@
// Port-level checks for i2c_adc_reader_averager_unit, bound to the top level.
// Depends on i2car_pkg for the result width.
`default_nettype none

module i2car_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [1:0]                   in_opcode,
  input wire logic                         in_sda_in,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_scl_out,
  input wire logic                         out_sda_out,
  input wire logic                         out_busy_res,
  input wire logic                         out_done_res,
  input wire logic [i2car_pkg::RESULT_W-1:0] out_average_value,
  input wire logic                         cfg_we,
  input wire logic [1:0]                   cfg_index,
  input wire logic [7:0]                   cfg_wdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average_value)
      && $stable(out_done_res) && $stable(out_busy_res))
    else $error("stalled result changed");

  // mean shows only on a done transfer
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_average_value == '0)
    else $error("average outside done");

  // a finished command leaves the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done while busy");

  // idle bus has both lines released
  a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_scl_out && out_sda_out)
    else $error("line held low while idle");

endmodule

bind i2c_adc_reader_averager_unit i2car_chk u_chk (.*);

`default_nettype wire

@@ test/i2car_bus_checker.sv @@
// Bus sequencer checker for the I2C converter reader: predicts every result
// from the input and register transfers it observes. Depends on i2car_pkg.
module i2car_bus_checker #(
  parameter int NumSamples = i2car_pkg::NUM_SAMPLES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic                             in_sda_in,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_scl_out,
  input  logic                             out_sda_out,
  input  logic                             out_busy_res,
  input  logic                             out_done_res,
  input  logic [i2car_pkg::RESULT_W-1:0]   out_average_value,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [7:0]                       cfg_wdata,
  output int                               fail_count,
  output int                               n_pending,
  output logic                             bus_busy
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2car_pkg::*;

  // byte after the low byte of a read; never summed
  localparam logic [1:0] SLOT_DISCARD = 2'd3;

  typedef struct packed {
    logic                scl;
    logic                sda;
    logic                busy;
    logic                done;
    logic [RESULT_W-1:0] avg;
  } line_view_t;

  line_view_t views_due[$];

  logic [6:0]          dev_addr;
  logic [7:0]          setup_val;
  logic [7:0]          hold_ticks;
  phase_t              ph;
  logic [7:0]          tcnt;
  logic [2:0]          bidx;
  logic [7:0]          shreg;
  logic [7:0]          hi_byte;
  int                  n_reads;
  logic [19:0]         acc;
  logic [RESULT_W-1:0] mean;
  logic                scl_drv, sda_drv, rd, done_now;
  logic [1:0]          slot;

  task automatic go(input phase_t p);
    ph = p;
    tcnt = '0;
    case (p)
      PH_ST_A: begin
        scl_drv = 1'b1;
        sda_drv = 1'b1;
      end
      PH_ST_B: sda_drv = 1'b0;
      PH_ST_C: scl_drv = 1'b0;
      PH_TX_D: begin
        scl_drv = 1'b0;
        sda_drv = shreg[7];
      end
      PH_TX_H: scl_drv = 1'b1;
      PH_TX_L: begin
        scl_drv = 1'b0;
        sda_drv = (bidx == BYTE_LAST_BIT) ? 1'b1 : shreg[7];
      end
      PH_AK_R: sda_drv = 1'b1;
      PH_AK_H: scl_drv = 1'b1;
      PH_AK_L: scl_drv = 1'b0;
      PH_RX_H: scl_drv = 1'b1;
      PH_RX_L: scl_drv = 1'b0;
      PH_MA_D: sda_drv = 1'b0;
      PH_MA_H: scl_drv = 1'b1;
      PH_MA_L: scl_drv = 1'b0;
      PH_MA_R: sda_drv = 1'b1;
      PH_NK_D: sda_drv = 1'b1;
      PH_NK_H: scl_drv = 1'b1;
      PH_NK_L: scl_drv = 1'b0;
      PH_SP_D: sda_drv = 1'b0;
      PH_SP_H: scl_drv = 1'b1;
      PH_SP_R: sda_drv = 1'b1;
      default: begin
        scl_drv = 1'b1;
        sda_drv = 1'b1;
      end
    endcase
  endtask

  task automatic load_byte(input logic [7:0] b);
    shreg = b;
    bidx = '0;
    go(PH_TX_D);
  endtask

  task automatic start_rx();
    shreg = '0;
    bidx = '0;
    go(PH_RX_H);
  endtask

  task automatic reset_model();
    dev_addr = DEVICE_ADDRESS_RST;
    setup_val = SETUP_BYTE_RST;
    hold_ticks = PHASE_TICKS_RST;
    ph = PH_IDLE;
    tcnt = '0;
    bidx = '0;
    shreg = '0;
    hi_byte = '0;
    n_reads = 0;
    acc = '0;
    mean = '0;
    scl_drv = 1'b1;
    sda_drv = 1'b1;
    rd = 1'b0;
    slot = SLOT_FIRST;
    done_now = 1'b0;
  endtask

  // one bus step, taken once the current level has been held long enough
  task automatic advance(input logic sd);
    case (ph)
      PH_ST_A: go(sd ? PH_ST_B : PH_ST_A);
      PH_ST_B: go(sd ? PH_ST_A : PH_ST_C);
      PH_ST_C: begin
        slot = SLOT_FIRST;
        load_byte({dev_addr, rd});
      end
      PH_TX_D: go(PH_TX_H);
      PH_TX_H: go(PH_TX_L);
      PH_TX_L: begin
        shreg = shreg << 1;
        if (bidx == BYTE_LAST_BIT) begin
          go(PH_AK_R);
        end else begin
          bidx = bidx + 3'd1;
          go(PH_TX_D);
        end
      end
      PH_AK_R: go(PH_AK_H);
      PH_AK_H: go(sd ? PH_AK_R : PH_AK_L);
      PH_AK_L: begin
        if (rd) begin
          slot = SLOT_SECOND;
          start_rx();
        end else if (slot == SLOT_FIRST) begin
          slot = SLOT_SECOND;
          load_byte(setup_val);
        end else begin
          go(PH_SP_D);
        end
      end
      PH_RX_H: begin
        shreg = {shreg[6:0], sd};
        go(PH_RX_L);
      end
      PH_RX_L: begin
        if (bidx != BYTE_LAST_BIT) begin
          bidx = bidx + 3'd1;
          go(PH_RX_H);
        end else if (slot == SLOT_SECOND) begin
          hi_byte = shreg;
          go(PH_MA_D);
        end else if (slot == SLOT_THIRD) begin
          acc = acc + {4'd0, hi_byte, shreg};
          go(PH_MA_D);
        end else begin
          go(PH_NK_D);
        end
      end
      PH_MA_D: go(PH_MA_H);
      PH_MA_H: go(PH_MA_L);
      PH_MA_L: go(PH_MA_R);
      PH_MA_R: begin
        slot = (slot == SLOT_SECOND) ? SLOT_THIRD : SLOT_DISCARD;
        start_rx();
      end
      PH_NK_D: go(PH_NK_H);
      PH_NK_H: go(PH_NK_L);
      PH_NK_L: go(PH_SP_D);
      PH_SP_D: go(PH_SP_H);
      PH_SP_H: go(PH_SP_R);
      PH_SP_R: begin
        if (rd) begin
          n_reads++;
          if (n_reads >= NumSamples) begin
            mean = RESULT_W'(acc / NumSamples);
            done_now = 1'b1;
            go(PH_IDLE);
          end else begin
            go(PH_ST_A);
          end
        end else begin
          done_now = 1'b1;
          go(PH_IDLE);
        end
      end
      default: go(PH_IDLE);
    endcase
  endtask

  task automatic bus_tick(input logic [1:0] op, input logic sd);
    logic [7:0] hold;
    hold = (hold_ticks == 8'd0) ? 8'd1 : hold_ticks;
    done_now = 1'b0;
    if (ph == PH_IDLE) begin
      if (op == OP_CONFIG || op == OP_READ) begin
        rd = (op == OP_READ);
        slot = SLOT_FIRST;
        if (rd) begin
          acc = '0;
          n_reads = 0;
        end
        go(PH_ST_A);
      end
    end else begin
      tcnt = tcnt + 8'd1;
      if (tcnt >= hold) advance(sd);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    line_view_t want;
    if (!rst_n) begin
      reset_model();
      views_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (views_due.size() == 0) begin
          fail_count++;
          $display("%0t ns: result transfer with nothing expected", $time);
        end else begin
          want = views_due.pop_front();
          check_field("scl_out", want.scl, out_scl_out);
          check_field("sda_out", want.sda, out_sda_out);
          check_field("busy_res", want.busy, out_busy_res);
          check_field("done_res", want.done, out_done_res);
          check_field("average_value", want.avg, out_average_value);
        end
      end
      if (in_valid && in_ready) begin
        bus_tick(in_opcode, in_sda_in);
        views_due.push_back('{scl_drv, sda_drv, ph != PH_IDLE, done_now,
                              (done_now && rd) ? mean : '0});
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS: dev_addr = cfg_wdata[6:0];
          CFG_SETUP_BYTE:     setup_val = cfg_wdata;
          CFG_PHASE_TICKS:    hold_ticks = cfg_wdata;
          default: ;
        endcase
      end
    end
    n_pending = views_due.size();
    bus_busy = (ph != PH_IDLE);
  end

endmodule

@@ test/i2c_adc_reader_averager_unit_tb.sv @@
// Testbench top for i2c_adc_reader_averager_unit: clock, reset, stimulus and verdict.
// Depends on i2car_pkg, the block itself and i2car_bus_checker.
module i2c_adc_reader_averager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2car_pkg::*;

  // opcode 3 behaves as a plain tick
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid, in_ready;
  logic [1:0]          in_opcode;
  logic                in_sda_in;
  logic                out_valid, out_ready;
  logic                out_scl_out, out_sda_out, out_busy_res, out_done_res;
  logic [RESULT_W-1:0] out_average_value;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [7:0]          cfg_wdata;
  int                  fail_count, n_pending;
  logic                bus_busy;
  int                  send_idle, recv_stall;

  always #4 clk = ~clk;

  i2c_adc_reader_averager_unit #(.NumSamples(NUM_SAMPLES)) u_top (.*);

  i2car_bus_checker #(.NumSamples(NUM_SAMPLES)) u_checker (.*);

  always @(negedge clk)
    out_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);

  // leaves valid high on return; the caller either sends again or lowers it
  task automatic send_item(input logic [1:0] op, input logic sd);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_sda_in <= sd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
  endtask

  // tick until the bus transaction ends, then let the pipeline empty
  task automatic settle_bus();
    while (bus_busy) send_item(OP_TICK, 1'($urandom_range(1)));
    wait_drained();
    repeat (4) @(negedge clk);
  endtask

  task automatic load_regs(input logic [6:0] addr, input logic [7:0] setup,
                           input logic [7:0] ticks);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_wdata <= {1'b0, addr};
    @(negedge clk);
    cfg_index <= CFG_SETUP_BYTE;
    cfg_wdata <= setup;
    @(negedge clk);
    cfg_index <= CFG_PHASE_TICKS;
    cfg_wdata <= ticks;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [1:0] pick_op(input bit no_read);
    int r;
    r = $urandom_range(99);
    if (r < 12) return OP_CONFIG;
    if (r < 30 && !no_read) return OP_READ;
    if (r < 36) return OP_SPARE;
    return OP_TICK;
  endfunction

  // the bus transaction may carry on into the next phase
  task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
                           input bit no_read, input bit mid_pause);
    send_idle = idle_pct;
    recv_stall = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) wait_drained();
      send_item(pick_op(no_read), 1'($urandom_range(1)));
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_TICK;
    in_sda_in = 1'b1;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DEVICE_ADDRESS;
    cfg_wdata = '0;
    send_idle = 0;
    recv_stall = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle ticks, a configure at reset settings, commands while busy
    send_item(OP_SPARE, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_CONFIG, 1'b1);
    send_item(OP_READ, 1'b1);
    send_item(OP_CONFIG, 1'b0);
    send_item(OP_SPARE, 1'b1);
    send_item(OP_TICK, 1'b0);
    repeat (30) send_item(OP_TICK, 1'($urandom_range(1)));
    wait_drained();
    // fastest bus, all-ones address and setup, switched while the configure runs
    load_regs(7'd127, 8'd255, 8'd1);
    settle_bus();

    // one full averaged read, carried across every stall pattern
    send_item(OP_READ, 1'b1);
    run_phase(200, 0, 0, 1'b0, 1'b0);
    load_regs(7'($urandom), 8'($urandom), 8'd2);
    run_phase(120, 87, 0, 1'b0, 1'b0);
    // zero hold counts as one
    load_regs(7'($urandom), 8'($urandom), 8'd0);
    run_phase(120, 0, 87, 1'b0, 1'b0);
    load_regs(7'($urandom), 8'($urandom), 8'd1);
    run_phase(200, 31, 31, 1'b0, 1'b1);
    settle_bus();
    // slowest bus: only the held start of a configure fits
    load_regs(7'($urandom), 8'($urandom), 8'd255);
    run_phase(30, 0, 0, 1'b1, 1'b0);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && n_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/i2car_pkg.sv
rtl/core/i2car_avg.sv
rtl/core/i2car_seq.sv
rtl/core/i2c_adc_reader_averager_unit.sv
rtl/core/i2car_chk.sv
test/i2car_bus_checker.sv
test/i2c_adc_reader_averager_unit_tb.sv
